// ===== hdl/i2cms_pkg.sv =====
// i2cms_pkg: request and response payload types, command codes and register
// indexes of the i2c master bit sequencer
// no dependencies
package i2cms_pkg;

   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUARTER_BIT_TICKS = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACK_EXTRA_TICKS = 1'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] QUARTER_BIT_TICKS_RESET = 16'd250;
   localparam logic [CSR_DATA_WIDTH-1:0] ACK_EXTRA_TICKS_RESET = 16'd25;

   // command codes carried in the action field
   localparam logic [1:0] ACTION_TICK = 2'd0;
   localparam logic [1:0] ACTION_START = 2'd1;
   localparam logic [1:0] ACTION_STOP = 2'd2;
   localparam logic [1:0] ACTION_WRITE = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
      logic       sda_line;
   } i2cms_req_type;

   typedef struct packed {
      logic scl_level;
      logic sda_level;
      logic busy_res;
      logic done_res;
      logic ack_valid;
      logic nack;
      logic rejected;
   } i2cms_rsp_type;

endpackage

// ===== hdl/i2c_master_bit_sequencer.sv =====
// i2c_master_bit_sequencer: start, stop and write-byte sequencer with acknowledge,
// one request per bit-timing tick
// depends on i2cms_pkg
//
// channel  direction  handshake                payload
// req      in         req_valid / req_stall    i2cms_req_type (action, data_byte, sda_line)
// rsp      out        rsp_valid / rsp_stall    i2cms_rsp_type (line levels and status)
// csr      in         csr_wr_en                csr_index, csr_wdata
//
// every request passes from acceptance through the input register, then through
// the sequencer step into the response register
// one request per cycle is sustained while rsp is not stalled; the step logic
// (a 17-bit tick compare) sits between the input register and the response register
// reset returns the lines to released, the sequencer to idle and the registers
// to 250 and 25 ticks; stalls on rsp back up into req_stall the same cycle
module i2c_master_bit_sequencer
   import i2cms_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  i2cms_req_type              req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output i2cms_rsp_type              rsp_data,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      KIND_IDLE  = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2,
      KIND_WRITE = 2'd3
   } kind_type;

   // write sequence phases
   localparam logic [3:0] PH_SETUP = 4'd0;
   localparam logic [3:0] PH_DATA = 4'd1;
   localparam logic [3:0] PH_HIGH = 4'd2;
   localparam logic [3:0] PH_ACK_LOW = 4'd3;
   localparam logic [3:0] PH_ACK_HIGH = 4'd4;
   localparam logic [3:0] PH_ACK_EXTRA = 4'd5;
   // stop and start phases
   localparam logic [3:0] PH_1 = 4'd1;
   localparam logic [3:0] PH_2 = 4'd2;
   localparam logic [3:0] PH_3 = 4'd3;
   localparam logic [3:0] PH_4 = 4'd4;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   logic [CSR_DATA_WIDTH-1:0] quarter_ff;
   logic [CSR_DATA_WIDTH-1:0] ack_extra_ff;

   logic          req_valid_ff;
   i2cms_req_type req_data_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   i2cms_rsp_type rsp_data_ff;
   i2cms_rsp_type rsp_data_in;

   kind_type    kind_ff, kind_in;
   logic [3:0]  phase_ff, phase_in;
   logic [16:0] tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;

   logic        advance_ok;
   logic        fire;
   logic [15:0] quarter_eff;
   logic [16:0] step_len;
   logic [16:0] tick_inc;
   logic        step_end;
   logic        seq_end;
   kind_type    kind_w;
   logic [3:0]  phase_w;
   logic [3:0]  bit_w;
   logic [7:0]  shift_w;
   logic [3:0]  phase_next;
   logic [3:0]  bit_next;

   assign advance_ok = !rsp_valid_ff || !rsp_stall;
   assign fire = req_valid_ff && advance_ok;
   assign req_stall = req_valid_ff && !advance_ok;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign quarter_eff = (quarter_ff == '0) ? 16'd1 : quarter_ff;
   assign phase_next = phase_w + 4'd1;
   assign bit_next = bit_w + 4'd1;

   always_comb begin
      kind_w = kind_ff;
      phase_w = phase_ff;
      bit_w = bit_ff;
      shift_w = shift_ff;
      tick_inc = tick_ff;
      rsp_data_in = '0;
      scl_in = scl_ff;
      sda_in = sda_ff;
      phase_in = phase_ff;
      bit_in = bit_ff;
      shift_in = shift_ff;
      tick_in = tick_ff;
      step_len = {1'b0, quarter_eff};
      step_end = 1'b0;
      seq_end = 1'b0;

      // a command is taken only while idle, otherwise it is flagged
      if (kind_ff != KIND_IDLE) begin
         rsp_data_in.rejected = (req_data_ff.action != ACTION_TICK);
         tick_inc = tick_ff;
      end else if (req_data_ff.action != ACTION_TICK) begin
         kind_w = kind_type'(req_data_ff.action);
         phase_w = '0;
         bit_w = '0;
         shift_w = req_data_ff.data_byte;
         tick_inc = '0;
      end

      if (kind_w != KIND_IDLE) begin
         // line levels for the current phase
         unique case (kind_w)
            KIND_START: begin
               scl_in = 1'b1;
               sda_in = (phase_w == '0);
            end
            KIND_STOP: begin
               scl_in = (phase_w >= PH_2);
               if (phase_w == PH_1 || phase_w == PH_2) begin
                  sda_in = 1'b0;
               end else if (phase_w == PH_3) begin
                  sda_in = 1'b1;
               end
            end
            default: begin
               unique case (phase_w)
                  PH_SETUP: scl_in = 1'b0;
                  PH_DATA: begin
                     scl_in = 1'b0;
                     sda_in = shift_w[7];
                  end
                  PH_HIGH: begin
                     scl_in = 1'b1;
                     sda_in = shift_w[7];
                  end
                  PH_ACK_LOW: begin
                     scl_in = 1'b0;
                     sda_in = 1'b1;
                  end
                  default: begin
                     scl_in = 1'b1;
                     sda_in = 1'b1;
                  end
               endcase
            end
         endcase

         rsp_data_in.busy_res = 1'b1;
         rsp_data_in.scl_level = scl_in;
         rsp_data_in.sda_level = sda_in;

         priority if (kind_w == KIND_START) begin
            step_len = {quarter_eff, 1'b0};
         end else if (kind_w == KIND_STOP) begin
            step_len = {1'b0, quarter_eff};
         end else if (phase_w == PH_SETUP || phase_w == PH_DATA) begin
            step_len = {1'b0, quarter_eff};
         end else if (phase_w == PH_ACK_EXTRA) begin
            step_len = {1'b0, ack_extra_ff};
         end else begin
            step_len = {quarter_eff, 1'b0};
         end

         tick_in = tick_inc + 17'd1;
         phase_in = phase_w;
         bit_in = bit_w;
         shift_in = shift_w;
         step_end = (tick_in >= step_len);

         if (step_end) begin
            tick_in = '0;
            priority if (kind_w == KIND_START) begin
               phase_in = phase_next;
               seq_end = (phase_next >= PH_2);
            end else if (kind_w == KIND_STOP) begin
               phase_in = phase_next;
               seq_end = (phase_next >= PH_4);
            end else if (phase_w == PH_HIGH) begin
               shift_in = {shift_w[6:0], 1'b0};
               bit_in = bit_next;
               phase_in = (bit_next >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_SETUP;
            end else if (phase_w == PH_ACK_HIGH) begin
               if (ack_extra_ff == '0) begin
                  seq_end = 1'b1;
               end else begin
                  phase_in = PH_ACK_EXTRA;
               end
            end else if (phase_w >= PH_ACK_EXTRA) begin
               seq_end = 1'b1;
            end else begin
               phase_in = phase_next;
            end
         end

         if (seq_end) begin
            rsp_data_in.done_res = 1'b1;
            if (kind_w == KIND_WRITE) begin
               // acknowledge sampled on the last scl-high tick
               rsp_data_in.ack_valid = 1'b1;
               rsp_data_in.nack = req_data_ff.sda_line;
               scl_in = 1'b0;
            end
            phase_in = '0;
            bit_in = '0;
         end
      end else begin
         rsp_data_in.scl_level = scl_ff;
         rsp_data_in.sda_level = sda_ff;
      end

      kind_in = seq_end ? KIND_IDLE : kind_w;
      rsp_valid_in = advance_ok ? req_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quarter_ff <= QUARTER_BIT_TICKS_RESET;
         ack_extra_ff <= ACK_EXTRA_TICKS_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kind_ff <= KIND_IDLE;
         phase_ff <= '0;
         tick_ff <= '0;
         bit_ff <= '0;
         shift_ff <= '0;
         scl_ff <= 1'b1;
         sda_ff <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_QUARTER_BIT_TICKS: quarter_ff <= csr_wdata;
               CSR_ACK_EXTRA_TICKS: ack_extra_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (!req_valid_ff || advance_ok) begin
            req_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            kind_ff <= kind_in;
            phase_ff <= phase_in;
            tick_ff <= tick_in;
            bit_ff <= bit_in;
            shift_ff <= shift_in;
            scl_ff <= scl_in;
            sda_ff <= sda_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (!req_valid_ff || advance_ok) begin
         req_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // an acknowledge only closes a write, on a high scl tick
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.ack_valid |-> rsp_data_ff.done_res && rsp_data_ff.scl_level)
      else $error("acknowledge reported outside the end of an scl-high tick");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.nack |-> rsp_data_ff.ack_valid)
      else $error("nack without acknowledge");

   assert property (@(posedge clock) disable iff (reset)
      kind_ff == KIND_IDLE |-> phase_ff == '0 && bit_ff == '0)
      else $error("idle sequencer holds stale phase or bit count");

   assert property (@(posedge clock) disable iff (reset)
      bit_ff <= BITS_PER_BYTE)
      else $error("bit count beyond one byte");

   // a finished write leaves scl driven low for the following ticks
   assert property (@(posedge clock) disable iff (reset)
      fire && seq_end && kind_w == KIND_WRITE |=> kind_ff == KIND_IDLE && !scl_ff)
      else $error("write did not return to idle with scl low");

endmodule

// ===== sim/testbench.sv =====
// testbench for i2c_master_bit_sequencer: paced random and directed requests,
// scoreboard class predicts scl/sda levels and status per tick
// depends on i2cms_pkg and the i2c_master_bit_sequencer rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import i2cms_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_OFF_AFTER = 600;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int NUM_SETTINGS = 9;

   class i2c_line_scoreboard;
      logic [15:0] quarter_ticks = QUARTER_BIT_TICKS_RESET;
      logic [15:0] ack_extra = ACK_EXTRA_TICKS_RESET;
      logic [1:0] seq_kind = ACTION_TICK;
      logic [3:0] phase = '0;
      logic [16:0] tick_cnt = '0;
      logic [3:0] bit_cnt = '0;
      logic [7:0] shift_reg = '0;
      logic scl_q = 1'b1;
      logic sda_q = 1'b1;
      i2cms_rsp_type expected_levels[$];
      int mismatches = 0;
      int levels_seen = 0;

      function void write_register(logic [CSR_INDEX_WIDTH-1:0] index, logic [15:0] value);
         if (index == CSR_QUARTER_BIT_TICKS) quarter_ticks = value;
         else if (index == CSR_ACK_EXTRA_TICKS) ack_extra = value;
      endfunction

      function bit busy();
         return seq_kind != ACTION_TICK;
      endfunction

      function logic [16:0] step_length();
         logic [16:0] q;
         q = (quarter_ticks == 0) ? 17'd1 : {1'b0, quarter_ticks};
         if (seq_kind == ACTION_START) return q << 1;
         if (seq_kind == ACTION_STOP) return q;
         case (phase)
            4'd0, 4'd1: return q;
            4'd5: return {1'b0, ack_extra};
            default: return q << 1;
         endcase
      endfunction

      function void drive_lines();
         if (seq_kind == ACTION_START) begin
            scl_q = 1'b1;
            sda_q = (phase == 0);
         end else if (seq_kind == ACTION_STOP) begin
            scl_q = (phase >= 2);
            if (phase == 1 || phase == 2) sda_q = 1'b0;
            else if (phase == 3) sda_q = 1'b1;
         end else begin
            case (phase)
               4'd0: scl_q = 1'b0;
               4'd1: begin
                  scl_q = 1'b0;
                  sda_q = shift_reg[7];
               end
               4'd2: begin
                  scl_q = 1'b1;
                  sda_q = shift_reg[7];
               end
               4'd3: begin
                  scl_q = 1'b0;
                  sda_q = 1'b1;
               end
               default: begin
                  scl_q = 1'b1;
                  sda_q = 1'b1;
               end
            endcase
         end
      endfunction

      // moves to the next step, returns 1 when the whole sequence is over
      function bit next_step();
         tick_cnt = '0;
         if (seq_kind == ACTION_START) begin
            phase++;
            return phase >= 2;
         end
         if (seq_kind == ACTION_STOP) begin
            phase++;
            return phase >= 4;
         end
         if (phase == 2) begin
            shift_reg = shift_reg << 1;
            bit_cnt = bit_cnt + 1'b1;
            phase = (bit_cnt >= 8) ? 4'd3 : 4'd0;
            return 1'b0;
         end
         if (phase == 4) begin
            if (ack_extra == 0) return 1'b1;
            phase = 4'd5;
            return 1'b0;
         end
         if (phase >= 5) return 1'b1;
         phase++;
         return 1'b0;
      endfunction

      function void predict_tick(i2cms_req_type r);
         i2cms_rsp_type e;
         e = '0;
         if (seq_kind != ACTION_TICK) begin
            if (r.action != ACTION_TICK) e.rejected = 1'b1;
         end else if (r.action != ACTION_TICK) begin
            seq_kind = r.action;
            phase = '0;
            tick_cnt = '0;
            bit_cnt = '0;
            shift_reg = r.data_byte;
         end
         if (seq_kind != ACTION_TICK) begin
            e.busy_res = 1'b1;
            drive_lines();
            e.scl_level = scl_q;
            e.sda_level = sda_q;
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= step_length()) begin
               if (next_step()) begin
                  e.done_res = 1'b1;
                  // acknowledge sampled on the last scl-high tick of a write
                  if (seq_kind == ACTION_WRITE) begin
                     e.ack_valid = 1'b1;
                     e.nack = r.sda_line;
                     scl_q = 1'b0;
                  end
                  seq_kind = ACTION_TICK;
                  phase = '0;
                  bit_cnt = '0;
               end
            end
         end else begin
            e.scl_level = scl_q;
            e.sda_level = sda_q;
         end
         expected_levels.push_back(e);
      endfunction

      function string show(i2cms_rsp_type v);
         return $sformatf("scl %b sda %b busy %b done %b ackv %b nack %b rej %b",
            v.scl_level, v.sda_level, v.busy_res, v.done_res, v.ack_valid, v.nack,
            v.rejected);
      endfunction

      function void flag(string text);
         mismatches++;
         if (mismatches <= 10) $display("%s", text);
      endfunction

      function void check_levels(i2cms_rsp_type got);
         i2cms_rsp_type want;
         levels_seen++;
         if (expected_levels.size() == 0) begin
            flag({"unexpected response: ", show(got)});
         end else begin
            want = expected_levels.pop_front();
            if (got !== want)
               flag({"response ", $sformatf("%0d", levels_seen), " expected ", show(want),
                     " got ", show(got)});
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   i2cms_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   i2cms_rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   i2c_line_scoreboard sb = new;
   int burst_left = 0;

   logic [15:0] setting_quarter[NUM_SETTINGS] = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd65535,
                                                  16'd1, 16'd4, 16'd1, 16'd2};
   logic [15:0] setting_ack[NUM_SETTINGS] = '{16'd0, 16'd1, 16'd7, 16'd2, 16'd65535,
                                              16'd3, 16'd0, 16'd65535, 16'd3};
   int setting_items[NUM_SETTINGS] = '{250, 300, 250, 300, 40, 250, 200, 30, 100};

   i2c_master_bit_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic i2cms_req_type make_req(logic [1:0] action, logic [7:0] data,
                                              logic line);
      i2cms_req_type r;
      r.action = action;
      r.data_byte = data;
      r.sda_line = line;
      return r;
   endfunction

   function automatic logic [1:0] command_code();
      case ($urandom_range(0, 2))
         0: return ACTION_START;
         1: return ACTION_STOP;
         default: return ACTION_WRITE;
      endcase
   endfunction

   // mostly whole sequences run to completion, with some noise and stray commands
   function automatic i2cms_req_type next_request();
      i2cms_req_type r;
      case ($urandom_range(0, 7))
         0: r.data_byte = 8'h00;
         1: r.data_byte = 8'hFF;
         default: r.data_byte = 8'($urandom_range(0, 255));
      endcase
      r.sda_line = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0)
         r.action = 2'($urandom_range(0, 3));
      else if (sb.busy())
         r.action = ($urandom_range(0, 24) == 0) ? command_code() : ACTION_TICK;
      else
         r.action = ($urandom_range(0, 7) == 0) ? ACTION_TICK : command_code();
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_paced(i2cms_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.predict_tick(r);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      while (sb.expected_levels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] index, logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.write_register(index, value);
      @(negedge clock);
   endtask

   task automatic apply_setting(logic [15:0] quarter, logic [15:0] ack);
      req_valid <= 1'b0;
      drain_responses();
      write_register(CSR_QUARTER_BIT_TICKS, quarter);
      write_register(CSR_ACK_EXTRA_TICKS, ack);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset levels and a start under the reset timing
      send_paced(make_req(ACTION_TICK, 8'h00, 1'b0));
      send_paced(make_req(ACTION_TICK, 8'hFF, 1'b1));
      send_paced(make_req(ACTION_START, 8'h5A, 1'b0));
      send_paced(make_req(ACTION_TICK, 8'h00, 1'b1));
      send_paced(make_req(ACTION_TICK, 8'h00, 1'b0));

      // zero quarter counts as one tick, shortens the running start at once
      apply_setting(16'd0, 16'd0);
      send_paced(make_req(ACTION_TICK, 8'h00, 1'b0));
      send_paced(make_req(ACTION_TICK, 8'h00, 1'b0));
      send_paced(make_req(ACTION_STOP, 8'h00, 1'b1));
      send_paced(make_req(ACTION_WRITE, 8'hFF, 1'b1));
      send_paced(make_req(ACTION_START, 8'h00, 1'b0));
      send_paced(make_req(ACTION_TICK, 8'h00, 1'b0));
      send_paced(make_req(ACTION_TICK, 8'h00, 1'b0));
      send_paced(make_req(ACTION_WRITE, 8'h00, 1'b0));

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         apply_setting(setting_quarter[s], setting_ack[s]);
         repeat (setting_items[s]) send_paced(next_request());
      end

      req_valid <= 1'b0;
      drain_responses();
      repeat (10) @(negedge clock);
      if (sb.mismatches == 0 && sb.expected_levels.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : receiver
      int mode;
      int mode_left;
      int phase_cnt;
      bit held;
      mode = 0;
      mode_left = 0;
      phase_cnt = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         // one long hold-off so the pipeline fills and the request side stalls
         if (!held && sb.levels_seen >= HOLD_OFF_AFTER) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            phase_cnt++;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               2: rsp_stall <= (phase_cnt % 3 == 0);
               default: rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_levels(rsp_data);
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/i2cms_pkg.sv
hdl/i2c_master_bit_sequencer.sv
sim/testbench.sv
